// ===== src/mor_pkg.sv =====
// ----------------------------------------------------------------------------
// mor_pkg
// Shared constants, types and helpers for the row-reorder max-rectangle block.
// ----------------------------------------------------------------------------
package mor_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 4096;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int NCOLS_W   = $clog2(MAX_COLS + 1);
    localparam int CFG_W     = 7;
    localparam int ADDR_W    = 2 * COL_W;
    localparam int DEPTH     = MAX_COLS * MAX_COLS;
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    localparam int WID_W     = NCOLS_W;
    localparam int PROD_W    = WID_W + CNT_W;
    localparam int AREA_W    = 19;
    localparam int AREA_MAX  = (1 << AREA_W) - 1;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int DRAIN_W   = 2;
    localparam int DRAIN_LEN = 3;

    // one command handed from the front to the back
    typedef struct packed {
        logic             one;
        logic             last;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] st;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_UPDATE,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT
    } t_back_state;

    // clamp the column register into 1..MAX_COLS
    function automatic logic [NCOLS_W-1:0] eff_cols(input logic [CFG_W-1:0] v);
        logic [NCOLS_W-1:0] res;
        if (v == '0) begin
            res = NCOLS_W'(1);
        end else if (CFG_W'(v) > CFG_W'(MAX_COLS)) begin
            res = NCOLS_W'(MAX_COLS);
        end else begin
            res = NCOLS_W'(v);
        end
        return res;
    endfunction

endpackage

// ===== src/mor_ifs.sv =====
// ----------------------------------------------------------------------------
// mor_ifs
// Valid/ready channel interfaces: cell input, area output, column config.
// ----------------------------------------------------------------------------
interface mor_in_if;
    logic valid;
    logic ready;
    logic cell_req;
    logic last;
    modport source(output valid, output cell_req, output last, input ready);
    modport sink(input valid, input cell_req, input last, output ready);
endinterface

interface mor_out_if;
    logic                        valid;
    logic                        ready;
    logic [mor_pkg::AREA_W-1:0]  max_area;
    modport source(output valid, output max_area, input ready);
    modport sink(input valid, input max_area, output ready);
endinterface

interface mor_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mor_pkg::CFG_W-1:0]   num_cols;
    modport source(output valid, output num_cols, input ready);
    modport sink(input valid, input num_cols, output ready);
endinterface

// ===== src/mor_ram.sv =====
// ----------------------------------------------------------------------------
// mor_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/mor_front.sv =====
// ----------------------------------------------------------------------------
// mor_front
// Accept cells, track column and run start, queue ones and end-of-matrix marks.
// ----------------------------------------------------------------------------
module mor_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mor_pkg::NCOLS_W-1:0]   i_cols,
    input  logic                          i_block,
    input  logic                          i_q_full,
    mor_in_if.sink                        i_in,
    output logic                          o_push,
    output mor_pkg::t_cell_cmd            o_cmd
);
    logic [mor_pkg::COL_W-1:0]   r_column_pos, n_column_pos;
    logic [mor_pkg::COL_W-1:0]   r_run_start, n_run_start;
    logic [mor_pkg::NCOLS_W-1:0] w_cols_dec;
    logic [mor_pkg::COL_W-1:0]   w_last_col;
    logic [mor_pkg::COL_W-1:0]   w_col;
    logic [mor_pkg::COL_W-1:0]   w_st;
    logic                        w_accept;

    assign w_cols_dec = i_cols - mor_pkg::NCOLS_W'(1);
    assign w_last_col = w_cols_dec[mor_pkg::COL_W-1:0];
    assign w_col      = (r_column_pos >= w_last_col) ? w_last_col : r_column_pos;
    assign w_st       = (r_run_start > w_col) ? w_col : r_run_start;

    assign i_in.ready = !i_q_full && !i_block;
    assign w_accept   = i_in.valid && i_in.ready;

    // zero cells that do not end the matrix only move the position
    assign o_push     = w_accept && (i_in.cell_req || i_in.last);
    assign o_cmd.one  = i_in.cell_req;
    assign o_cmd.last = i_in.last;
    assign o_cmd.col  = w_col;
    assign o_cmd.st   = w_st;

    always_comb begin
        n_column_pos = r_column_pos;
        n_run_start  = r_run_start;
        if (w_accept) begin
            if (!i_in.cell_req) begin
                n_run_start = w_col + mor_pkg::COL_W'(1);
            end
            if (w_col == w_last_col || i_in.last) begin
                n_column_pos = '0;
                n_run_start  = '0;
            end else begin
                n_column_pos = w_col + mor_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_pos <= '0;
            r_run_start  <= '0;
        end else begin
            r_column_pos <= n_column_pos;
            r_run_start  <= n_run_start;
        end
    end
endmodule

// ===== src/mor_queue.sv =====
// ----------------------------------------------------------------------------
// mor_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module mor_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mor_pkg::t_cell_cmd  i_cmd,
    input  logic                i_pop,
    output mor_pkg::t_cell_cmd  o_cmd,
    output logic                o_valid,
    output logic                o_full
);
    mor_pkg::t_cell_cmd                 r_slot [mor_pkg::Q_DEPTH];
    logic [mor_pkg::Q_PTR_W-1:0]        r_wr_ptr;
    logic [mor_pkg::Q_PTR_W-1:0]        r_rd_ptr;
    logic [mor_pkg::Q_CNT_W-1:0]        r_count;
    logic                               w_push;
    logic                               w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == mor_pkg::Q_CNT_W'(mor_pkg::Q_DEPTH));
    assign o_cmd   = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + mor_pkg::Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + mor_pkg::Q_PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + mor_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - mor_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

// ===== src/mor_back.sv =====
// ----------------------------------------------------------------------------
// mor_back
// Count-table updates, end-of-matrix sweep with clear, and the result register.
// ----------------------------------------------------------------------------
module mor_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mor_pkg::NCOLS_W-1:0]   i_cols,
    input  mor_pkg::t_cell_cmd            i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_pop,
    output logic                          o_init,
    mor_out_if.source                     o_out
);
    localparam int COL_W  = mor_pkg::COL_W;
    localparam int ADDR_W = mor_pkg::ADDR_W;
    localparam int CNT_W  = mor_pkg::CNT_W;
    localparam int WID_W  = mor_pkg::WID_W;
    localparam int AREA_W = mor_pkg::AREA_W;
    localparam int PROD_W = mor_pkg::PROD_W;

    mor_pkg::t_back_state        r_state, n_state;
    mor_pkg::t_cell_cmd          r_cmd, n_cmd;
    logic [ADDR_W-1:0]           r_init_addr, n_init_addr;
    logic [COL_W-1:0]            r_e, n_e;
    logic [COL_W-1:0]            r_s, n_s;
    logic [COL_W-1:0]            r_emax, n_emax;
    logic [COL_W-1:0]            r_max_col, n_max_col;
    logic [mor_pkg::DRAIN_W-1:0] r_drain, n_drain;
    logic [AREA_W-1:0]           r_best, n_best;
    logic                        r_out_valid, n_out_valid;
    logic [AREA_W-1:0]           r_out_area, n_out_area;

    // sweep pipeline
    logic                        r_p1_valid, r_p1_first, r_p1_use;
    logic [WID_W-1:0]            r_p1_w;
    logic [ADDR_W-1:0]           r_p1_addr;
    logic [CNT_W-1:0]            r_sum;
    logic                        r_p2_valid;
    logic [WID_W-1:0]            r_p2_w;
    logic                        r_p3_valid;
    logic [PROD_W-1:0]           r_prod;

    logic                        w_we;
    logic [ADDR_W-1:0]           w_waddr;
    logic [CNT_W-1:0]            w_wdata;
    logic [ADDR_W-1:0]           w_raddr;
    logic [CNT_W-1:0]            w_rdata;
    logic                        w_issue;
    logic [mor_pkg::NCOLS_W-1:0] w_cols_dec;
    logic [COL_W-1:0]            w_last_col;
    logic [COL_W-1:0]            w_upd_max;
    logic [CNT_W:0]              w_sum_wide;
    logic [CNT_W-1:0]            w_sum;
    logic [AREA_W-1:0]           w_area;

    assign w_cols_dec = i_cols - mor_pkg::NCOLS_W'(1);
    assign w_last_col = w_cols_dec[COL_W-1:0];
    assign w_upd_max  = (r_cmd.col > r_max_col) ? r_cmd.col : r_max_col;

    assign w_sum_wide = (r_p1_first ? '0 : {1'b0, r_sum}) + {1'b0, w_rdata};
    assign w_sum      = (w_sum_wide > (CNT_W+1)'(mor_pkg::MAX_ROWS))
                        ? CNT_W'(mor_pkg::MAX_ROWS) : w_sum_wide[CNT_W-1:0];
    assign w_area     = (r_prod > PROD_W'(mor_pkg::AREA_MAX))
                        ? AREA_W'(mor_pkg::AREA_MAX) : r_prod[AREA_W-1:0];

    assign o_init       = (r_state == mor_pkg::ST_INIT);
    assign o_out.valid    = r_out_valid;
    assign o_out.max_area = r_out_area;

    mor_ram #(
        .WIDTH (CNT_W),
        .DEPTH (mor_pkg::DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_init_addr = r_init_addr;
        n_e         = r_e;
        n_s         = r_s;
        n_emax      = r_emax;
        n_max_col   = r_max_col;
        n_drain     = r_drain;
        n_best      = r_best;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_area  = r_out_area;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_raddr     = {r_e, r_s};
        w_issue     = 1'b0;
        o_cmd_pop   = 1'b0;

        if (r_p3_valid && (w_area > r_best)) begin
            n_best = w_area;
        end

        unique case (r_state)
            mor_pkg::ST_INIT: begin
                w_we        = 1'b1;
                w_waddr     = r_init_addr;
                n_init_addr = r_init_addr + ADDR_W'(1);
                if (&r_init_addr) begin
                    n_state = mor_pkg::ST_IDLE;
                end
            end
            mor_pkg::ST_IDLE: begin
                w_raddr = {i_cmd.col, i_cmd.st};
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    if (i_cmd.one) begin
                        n_state = mor_pkg::ST_UPDATE;
                    end else begin
                        n_e     = '0;
                        n_s     = '0;
                        n_best  = '0;
                        n_emax  = (r_max_col > w_last_col) ? r_max_col : w_last_col;
                        n_state = mor_pkg::ST_SWEEP;
                    end
                end
            end
            mor_pkg::ST_UPDATE: begin
                w_we      = 1'b1;
                w_waddr   = {r_cmd.col, r_cmd.st};
                w_wdata   = (w_rdata < CNT_W'(mor_pkg::MAX_ROWS))
                            ? w_rdata + CNT_W'(1) : w_rdata;
                n_max_col = w_upd_max;
                if (r_cmd.last) begin
                    n_e     = '0;
                    n_s     = '0;
                    n_best  = '0;
                    n_emax  = (w_upd_max > w_last_col) ? w_upd_max : w_last_col;
                    n_state = mor_pkg::ST_SWEEP;
                end else begin
                    n_state = mor_pkg::ST_IDLE;
                end
            end
            mor_pkg::ST_SWEEP: begin
                w_issue = 1'b1;
                if (r_s == r_e) begin
                    n_s = '0;
                    if (r_e == r_emax) begin
                        n_drain = '0;
                        n_state = mor_pkg::ST_DRAIN;
                    end else begin
                        n_e = r_e + COL_W'(1);
                    end
                end else begin
                    n_s = r_s + COL_W'(1);
                end
            end
            mor_pkg::ST_DRAIN: begin
                n_drain = r_drain + mor_pkg::DRAIN_W'(1);
                if (r_drain == mor_pkg::DRAIN_W'(mor_pkg::DRAIN_LEN - 1)) begin
                    n_state = mor_pkg::ST_EMIT;
                end
            end
            mor_pkg::ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_area  = r_best;
                    n_max_col   = '0;
                    n_state     = mor_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mor_pkg::ST_IDLE;
            end
        endcase

        // clear each counter once the sweep has read it
        if (r_p1_valid) begin
            w_we    = 1'b1;
            w_waddr = r_p1_addr;
            w_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mor_pkg::ST_INIT;
            r_init_addr <= '0;
            r_max_col   <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_max_col   <= n_max_col;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
            r_p1_valid  <= w_issue;
            r_p2_valid  <= r_p1_valid && r_p1_use;
            r_p3_valid  <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_e        <= n_e;
        r_s        <= n_s;
        r_emax     <= n_emax;
        r_best     <= n_best;
        r_out_area <= n_out_area;
        r_p1_first <= (r_s == '0);
        r_p1_use   <= ({1'b0, r_e} < i_cols);
        r_p1_w     <= {1'b0, r_e} - {1'b0, r_s} + WID_W'(1);
        r_p1_addr  <= {r_e, r_s};
        r_sum      <= w_sum;
        r_p2_w     <= r_p1_w;
        r_prod     <= PROD_W'(r_p2_w) * PROD_W'(r_sum);
    end
endmodule

// ===== src/max_ones_rectangle_row_reorder.sv =====
// ----------------------------------------------------------------------------
// max_ones_rectangle_row_reorder
// Largest all-ones rectangle of a binary matrix whose rows may be reordered.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one matrix cell per transaction in row-major order (cell_req)
//   with last set on the final cell. o_out carries one transaction per matrix,
//   max_area, produced for the cell marked last. i_cfg writes num_cols, the row
//   width (0 acts as 1, above 64 acts as 64); write it only while idle.
// Flow:
//   A zero cell that does not end the matrix stays in the front. A one cell
//   takes two steps in the back, a read then a write of the count memory; a
//   four-entry queue lets the front keep taking cells while the back works.
//   After the last cell the back sweeps every (end, start) pair up to E, the
//   widest column in use or the row's last column if larger, clearing each
//   counter as it is read, then drains its sweep pipeline and loads the result.
// Reset:
//   A clearing pass over all 4096 count-memory entries zeroes the memory;
//   i_in.ready stays low during it, config writes are still taken.
// Stall:
//   The result waits in an output register; the back holds in its emit state
//   if an earlier result has not been taken, and the queue backs up to i_in.
// ----------------------------------------------------------------------------
module max_ones_rectangle_row_reorder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mor_in_if.sink     i_in,
    mor_cfg_if.sink    i_cfg,
    mor_out_if.source  o_out
);
    logic [mor_pkg::CFG_W-1:0]   r_num_cols;
    logic [mor_pkg::NCOLS_W-1:0] w_cols;
    logic                        w_push;
    mor_pkg::t_cell_cmd          w_push_cmd;
    mor_pkg::t_cell_cmd          w_head_cmd;
    logic                        w_head_valid;
    logic                        w_q_full;
    logic                        w_pop;
    logic                        w_init;

    // config register: always ready, take the write on handshake
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= mor_pkg::CFG_W'(mor_pkg::MAX_COLS);
        end else if (i_cfg.valid) begin
            r_num_cols <= i_cfg.num_cols;
        end
    end

    assign w_cols = mor_pkg::eff_cols(r_num_cols);

    // front: track position, drop plain zero cells, queue the rest
    mor_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cols   (w_cols),
        .i_block  (w_init),
        .i_q_full (w_q_full),
        .i_in     (i_in),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    mor_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_valid (w_head_valid),
        .o_full  (w_q_full)
    );

    // back: counter updates, sweep and result
    mor_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cols      (w_cols),
        .i_cmd       (w_head_cmd),
        .i_cmd_valid (w_head_valid),
        .o_cmd_pop   (w_pop),
        .o_init      (w_init),
        .o_out       (o_out)
    );
endmodule

// ===== src/mor_checker.sv =====
// ----------------------------------------------------------------------------
// mor_checker
// Port-level checks on the row-reorder max-rectangle block, bound to the top.
// ----------------------------------------------------------------------------
module mor_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_ready,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [mor_pkg::AREA_W-1:0]   i_max_area
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_max_area))
        else $error("result dropped or changed while stalled");

    // area never exceeds 64 columns times 4096 rows
    a_area_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_max_area <= mor_pkg::AREA_W'(mor_pkg::MAX_COLS * mor_pkg::MAX_ROWS)))
        else $error("area out of range");

    // the memory clearing pass blocks input right after reset
    a_reset_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready during clearing pass");

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind max_ones_rectangle_row_reorder mor_checker u_mor_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_max_area  (o_out.max_area)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for max_ones_rectangle_row_reorder. A table of directed
// cases runs first, then random matrices at a mix of row widths. Every
// max_area transaction is compared with a cycle-free software copy of the
// block's counting and sweep.
// ----------------------------------------------------------------------------
module tb;

    // Run sizing
    localparam int RAND_CELLS     = 1340;      // random cells before stopping
    localparam int SETTLE_CYCLES  = 24;        // back-end queue drain allowance
    localparam int HOLD_CYCLES    = 600;       // long receiver hold-off
    localparam int END_GUARD      = 50000;     // bound on the final drain
    localparam int TIMEOUT_CYCLES = 2000000;
    localparam int FROM_MODEL     = -1;        // no hand-typed area in a row

    typedef enum {ROW_CFG, ROW_CELLS} t_row_kind;

    // One directed row: either a num_cols write (bits[6:0]) or a bit pattern
    // of len cells, LSB first, sent reps times. last marks the final cell.
    typedef struct {
        t_row_kind   kind;
        logic [63:0] bits;
        int unsigned len;
        int unsigned reps;
        bit          last;
        int          area;
    } t_plan_row;

    localparam int PLAN_LEN = 20;

    logic clk = 1'b0;
    logic rst_n;

    mor_in_if  in_ch();
    mor_cfg_if cols_ch();
    mor_out_if area_ch();

    max_ones_rectangle_row_reorder DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cols_ch),
        .o_out   (area_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: row-width register, run tracking and the count store
    // ------------------------------------------------------------------------
    int unsigned                 run_counts [mor_pkg::MAX_COLS*mor_pkg::MAX_COLS];
    logic [mor_pkg::CFG_W-1:0]   cols_reg;
    int unsigned                 run_from;
    int unsigned                 next_col;
    logic [mor_pkg::AREA_W-1:0]  pending_areas [$];

    int unsigned        mismatches;
    int unsigned        cells_sent;

    // Idling controls shared with the drivers
    bit                 in_gaps;
    bit                 out_gaps;
    int unsigned        hold_asks;

    t_plan_row          plan [PLAN_LEN];

    // Row width in use: zero acts as one, anything above MAX_COLS as MAX_COLS
    function automatic int unsigned clamp_width(input logic [mor_pkg::CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > mor_pkg::MAX_COLS)
            return mor_pkg::MAX_COLS;
        return int'(v);
    endfunction

    // Append one expected area behind those already waiting
    function automatic void queue_area(input logic [mor_pkg::AREA_W-1:0] a);
        pending_areas = {pending_areas, a};
    endfunction

    // Walk every end column; accumulate counts from start 0 upward and keep
    // the widest-times-tallest product. Clear the store on the way out.
    function automatic logic [mor_pkg::AREA_W-1:0] sweep_area(input int unsigned w);
        longint      best;
        longint      prod;
        int unsigned acc;
        best = 0;
        for (int unsigned e = 0; e < w; e++) begin
            acc = 0;
            for (int unsigned s = 0; s <= e; s++) begin
                acc += run_counts[e*mor_pkg::MAX_COLS + s];
                if (acc > mor_pkg::MAX_ROWS)
                    acc = mor_pkg::MAX_ROWS;
                prod = longint'(e - s + 1) * longint'(acc);
                if (prod > best)
                    best = prod;
            end
        end
        foreach (run_counts[i])
            run_counts[i] = 0;
        if (best > mor_pkg::AREA_MAX)
            best = mor_pkg::AREA_MAX;
        return best[mor_pkg::AREA_W-1:0];
    endfunction

    // Advance the predictor by one accepted cell; queue an area on last
    function automatic void predict_cell(input bit one, input bit fin, input int typed_area);
        int unsigned                w;
        int unsigned                col;
        int unsigned                st;
        logic [mor_pkg::AREA_W-1:0] area;
        w   = clamp_width(cols_reg);
        // a position left over from a wider row folds onto the last column
        col = (next_col >= w - 1) ? w - 1 : next_col;
        if (one) begin
            st = (run_from > col) ? col : run_from;
            if (run_counts[col*mor_pkg::MAX_COLS + st] < mor_pkg::MAX_ROWS)
                run_counts[col*mor_pkg::MAX_COLS + st]++;
        end else begin
            run_from = col + 1;
        end
        if (col == w - 1) begin
            next_col = 0;
            run_from = 0;
        end else begin
            next_col = col + 1;
        end
        if (fin) begin
            area = sweep_area(w);
            if (typed_area >= 0)
                queue_area(mor_pkg::AREA_W'(typed_area));
            else
                queue_area(area);
            next_col = 0;
            run_from = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Drivers: inputs change on the falling edge, handshakes seen on rising
    // ------------------------------------------------------------------------

    // Offer one cell, with optional random idle cycles ahead of it
    task automatic push_cell(input bit one, input bit fin, input int typed_area);
        @(negedge clk);
        while (in_gaps && $urandom_range(99) < 38) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.cell_req <= one;
        in_ch.last     <= fin;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        predict_cell(one, fin, typed_area);
        cells_sent++;
    endtask

    // Drop valid, hold until every area has arrived, then let the back end
    // finish any cells still queued (they produce no transaction).
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_areas.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cols(input logic [mor_pkg::CFG_W-1:0] v);
        wait_idle();
        cols_ch.valid    <= 1'b1;
        cols_ch.num_cols <= v;
        @(posedge clk);
        while (cols_ch.ready !== 1'b1)
            @(posedge clk);
        cols_reg = v;
        @(negedge clk);
        cols_ch.valid <= 1'b0;
    endtask

    // Pick a width: mostly narrow rows, some wide, the edges now and then
    function automatic logic [mor_pkg::CFG_W-1:0] pick_cols();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return mor_pkg::CFG_W'($urandom_range(2, 8));
        if (r < 80)
            return mor_pkg::CFG_W'($urandom_range(9, mor_pkg::MAX_COLS));
        if (r < 88)
            return mor_pkg::CFG_W'(mor_pkg::MAX_COLS);
        if (r < 94)
            return mor_pkg::CFG_W'(1);
        return mor_pkg::CFG_W'($urandom_range(0, 127));
    endfunction

    // Send one matrix at the current width. A broken one stops early, with or
    // without last, so the next width write can land mid-row.
    task automatic send_matrix(input bit broken, input int unsigned max_rows);
        int unsigned w;
        int unsigned rows;
        int unsigned total;
        int unsigned cut;
        int unsigned k;
        int unsigned mode;
        int unsigned dens;
        int unsigned lo;
        int unsigned hi;
        bit          fin_at_cut;
        bit          one;
        w     = clamp_width(cols_reg);
        rows  = (w <= 8) ? $urandom_range(1, max_rows) : $urandom_range(1, 3);
        total = rows * w;
        cut   = broken ? $urandom_range(1, total) : total;
        fin_at_cut = broken ? bit'($urandom_range(1)) : 1'b1;
        k = 0;
        for (int unsigned r = 0; r < rows; r++) begin
            mode = $urandom_range(3);
            dens = ($urandom_range(2) == 0) ? 15 : ($urandom_range(1) ? 50 : 85);
            lo   = $urandom_range(0, w - 1);
            hi   = $urandom_range(lo, w - 1);
            for (int unsigned c = 0; c < w; c++) begin
                if (k == cut)
                    return;
                case (mode) inside
                    [0:1]: begin
                        one = (c >= lo) && (c <= hi);
                    end
                    2: begin
                        one = ($urandom_range(99) < dens);
                    end
                    default: begin
                        one = 1'b1;
                    end
                endcase
                push_cell(one, fin_at_cut && (k == cut - 1), FROM_MODEL);
                k++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : area_sink
        int unsigned hold_left;
        int unsigned served;
        hold_left     = 0;
        served        = 0;
        area_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (served != hold_asks) begin
                served    = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                area_ch.ready <= 1'b0;
            end else begin
                area_ch.ready <= !(out_gaps && $urandom_range(99) < 38);
            end
        end
    end

    // Compare each area transaction with the oldest expectation
    always @(posedge clk) begin : area_check
        logic [mor_pkg::AREA_W-1:0] want;
        if (rst_n === 1'b1 && area_ch.valid === 1'b1 && area_ch.ready === 1'b1) begin
            if (pending_areas.size() == 0) begin
                $error("max_area: unexpected transaction, expected none, actual %0d",
                       area_ch.max_area);
                mismatches++;
            end else begin
                want = pending_areas.pop_front();
                if (area_ch.max_area !== want) begin
                    $error("max_area: expected %0d, actual %0d", want, area_ch.max_area);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase;
        int unsigned rand_base;
        int unsigned guard;
        bit          fin;

        // Hold every input at a known value from time zero
        in_ch.valid      = 1'b0;
        in_ch.cell_req   = 1'b0;
        in_ch.last       = 1'b0;
        cols_ch.valid    = 1'b0;
        cols_ch.num_cols = '0;
        rst_n            = 1'b0;
        in_gaps          = 1'b1;
        out_gaps         = 1'b1;
        hold_asks        = 0;
        mismatches       = 0;
        cells_sent       = 0;

        // Predictor reset state
        foreach (run_counts[i])
            run_counts[i] = 0;
        cols_reg = mor_pkg::CFG_W'(mor_pkg::MAX_COLS);
        run_from = 0;
        next_col = 0;

        // Directed cases. Hand-typed areas where the answer is obvious.
        plan = '{
            // reset width of 64: one full row of ones
            '{ROW_CELLS, 64'hFFFF_FFFF_FFFF_FFFF, 64, 1,    1'b1, 64},
            // no ones at all
            '{ROW_CFG,   64'd3,                   0,  0,    1'b0, FROM_MODEL},
            '{ROW_CELLS, 64'b000,                 3,  2,    1'b1, 0},
            // width 0 behaves as width 1: each cell is a row
            '{ROW_CFG,   64'd0,                   0,  0,    1'b0, FROM_MODEL},
            '{ROW_CELLS, 64'b1,                   1,  3,    1'b1, 3},
            // register above range behaves as 64
            '{ROW_CFG,   64'd127,                 0,  0,    1'b0, FROM_MODEL},
            '{ROW_CELLS, 64'hFFFF_FFFF_FFFF_FFFF, 64, 2,    1'b1, 128},
            // rows that only line up once reordered
            '{ROW_CFG,   64'd4,                   0,  0,    1'b0, FROM_MODEL},
            '{ROW_CELLS, 64'b0110,                4,  1,    1'b0, FROM_MODEL},
            '{ROW_CELLS, 64'b0111,                4,  1,    1'b0, FROM_MODEL},
            '{ROW_CELLS, 64'b1110,                4,  1,    1'b1, FROM_MODEL},
            // narrow the row mid-way: position and run start both fold back
            '{ROW_CFG,   64'd10,                  0,  0,    1'b0, FROM_MODEL},
            '{ROW_CELLS, 64'b0111_1111,           8,  1,    1'b0, FROM_MODEL},
            '{ROW_CFG,   64'd4,                   0,  0,    1'b0, FROM_MODEL},
            '{ROW_CELLS, 64'b1,                   1,  1,    1'b1, FROM_MODEL},
            // counters left at wide columns must have been cleared
            '{ROW_CFG,   64'd10,                  0,  0,    1'b0, FROM_MODEL},
            '{ROW_CELLS, 64'b0,                   10, 1,    1'b1, 0},
            // a wide short block against a taller narrow column
            '{ROW_CFG,   64'd2,                   0,  0,    1'b0, FROM_MODEL},
            '{ROW_CELLS, 64'b11,                  2,  6,    1'b0, FROM_MODEL},
            '{ROW_CELLS, 64'b10,                  2,  4,    1'b1, FROM_MODEL}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                write_cols(plan[i].bits[mor_pkg::CFG_W-1:0]);
            end else begin
                for (int unsigned r = 0; r < plan[i].reps; r++) begin
                    for (int unsigned b = 0; b < plan[i].len; b++) begin
                        fin = plan[i].last && (r == plan[i].reps - 1) &&
                              (b == plan[i].len - 1);
                        push_cell(plan[i].bits[b], fin, fin ? plan[i].area : FROM_MODEL);
                    end
                end
            end
        end

        // Random phases: new width, then a few matrices. Every sixth phase
        // runs with no idling on either side.
        rand_base = cells_sent;
        phase     = 0;
        while ((cells_sent - rand_base) < RAND_CELLS) begin
            if (phase == 2 || phase == 30) begin
                // Hold the receiver off and keep the sender busy with small
                // matrices so the output register, back end and queue fill.
                write_cols(mor_pkg::CFG_W'(3));
                in_gaps  = 1'b0;
                out_gaps = 1'b1;
                hold_asks++;
                repeat (10) send_matrix(1'b0, 2);
            end else begin
                in_gaps  = (phase % 6 != 5);
                out_gaps = (phase % 6 != 5);
                write_cols(pick_cols());
                repeat ($urandom_range(1, 3))
                    send_matrix($urandom_range(99) < 15, 8);
            end
            phase++;
        end

        // Drain: wait for the outstanding areas, then a little longer for
        // anything stray.
        @(negedge clk);
        in_ch.valid <= 1'b0;
        guard = 0;
        while (pending_areas.size() != 0 && guard < END_GUARD) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (pending_areas.size() != 0) begin
            $error("max_area: expected %0d more transaction(s), actual 0",
                   pending_areas.size());
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
